// ----- rtl/sbdec_pkg.sv -----
// Shared constants and types for the signed binary to decimal ASCII converter.
// No dependencies; every other file imports this package.
package sbdec_pkg;

	localparam int MAG_W = 18;
	localparam int CHAR_W = 6;
	localparam int DIG_W = 4;
	localparam int PROD_W = 64;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'h2D;

	typedef struct packed {
		logic valid;
		logic neg;
	} ctl_t;

	function automatic logic [PROD_W-1:0] pow10(input int n);
		logic [PROD_W-1:0] p;
		p = 64'd1;
		for (int k = 0; k < n; k++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

endpackage

// ----- rtl/sbdec_cell.sv -----
// One digit cell of the conversion chain: extracts the digit of one power of ten.
// Depends on sbdec_pkg. Instantiated DIGITS times by the top level.
module sbdec_cell import sbdec_pkg::*; #(
	parameter int DIGITS = 5,
	parameter int POS = 0,
	localparam int CW = $clog2(DIGITS + 1),
	localparam int BW = DIGITS * DIG_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  ctl_t             ctl_in,
	input  logic [MAG_W-1:0] rem_in,
	input  logic [CW-1:0]    cnt_in,
	input  logic [BW-1:0]    digs_in,
	output ctl_t             ctl_out,
	output logic [MAG_W-1:0] rem_out,
	output logic [CW-1:0]    cnt_out,
	output logic [BW-1:0]    digs_out
);

	localparam logic [PROD_W-1:0] P = pow10(DIGITS - 1 - POS);

	logic [8:0]       ge;
	logic [MAG_W-1:0] sub [10];
	logic [DIG_W-1:0] d;
	logic [PROD_W-1:0] rem_ext;
	logic [MAG_W-1:0] rem_n;
	logic [CW-1:0]    cnt_n;
	logic [BW-1:0]    digs_n;
	ctl_t             ctl_q;
	logic [MAG_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic [BW-1:0]    digs_q;

	assign rem_ext = {{(PROD_W-MAG_W){1'b0}}, rem_in};
	assign sub[0] = '0;

	for (genvar m = 1; m <= 9; m++) begin : g_mult
		localparam logic [PROD_W-1:0] MP = PROD_W'(m) * P;
		assign ge[m-1] = rem_ext >= MP;
		assign sub[m] = MP[MAG_W-1:0];
	end

	always_comb begin
		d = '0;
		for (int i = 0; i < 9; i++) begin
			if (ge[i]) begin
				d = DIG_W'(i + 1);
			end
		end
		rem_n = rem_in - sub[d];
		cnt_n = cnt_in;
		digs_n = digs_in;
		if (d != '0 || cnt_in != '0) begin
			cnt_n = cnt_in + CW'(1);
			digs_n = digs_in << DIG_W;
			digs_n[DIG_W-1:0] = d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q <= rem_n;
			cnt_q <= cnt_n;
			digs_q <= digs_n;
		end
	end

	assign ctl_out = ctl_q;
	assign rem_out = rem_q;
	assign cnt_out = cnt_q;
	assign digs_out = digs_q;

endmodule

// ----- rtl/sbdec_ser.sv -----
// Output serializer: turns one converted number into a stream of ASCII characters.
// Depends on sbdec_pkg. Fed by the last cell of the chain.
module sbdec_ser import sbdec_pkg::*; #(
	parameter int DIGITS = 5,
	localparam int CW = $clog2(DIGITS + 1),
	localparam int BW = DIGITS * DIG_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl_in,
	input  logic [CW-1:0]     cnt_in,
	input  logic [BW-1:0]     digs_in,
	output logic              load,
	output logic              text_valid,
	input  logic              text_stall,
	output logic [CHAR_W-1:0] text_char,
	output logic              final_char
);

	logic          busy_q;
	logic          sign_q;
	logic [CW-1:0] left_q;
	logic [BW-1:0] digs_q;
	logic [DIG_W-1:0] sel;
	logic          take;

	assign text_valid = busy_q;
	assign take = busy_q && !text_stall;
	assign final_char = !sign_q && left_q <= CW'(1);
	assign load = ctl_in.valid && (!busy_q || (take && final_char));

	always_comb begin
		sel = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (left_q == CW'(i + 1)) begin
				sel = digs_q[i*DIG_W +: DIG_W];
			end
		end
		if (sign_q) begin
			text_char = CHAR_MINUS;
		end else begin
			text_char = CHAR_ZERO + {{(CHAR_W-DIG_W){1'b0}}, sel};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (take && final_char) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sign_q <= ctl_in.neg && cnt_in != '0;
			left_q <= cnt_in;
			digs_q <= digs_in;
		end else if (take) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				left_q <= left_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/signed_binary_to_decimal_ascii.sv -----
// Top level of the signed binary to decimal ASCII converter.
// Depends on sbdec_pkg, sbdec_cell and sbdec_ser.
//
// Usage: a transaction on the number channel (number_valid, number_stall,
// number) carries one signed 18-bit value. Each transaction on the text
// channel (text_valid, text_stall, text_char, final_char) carries one ASCII
// character of that value's decimal text: an optional minus sign and then
// the digits without leading zeros, or a single '0' for zero. final_char
// marks the last character. Magnitudes above 10^DIGITS - 1 print as nines.
// A number passes a front register, a chain of DIGITS digit cells, one
// per power of ten, and the serializer register before its first character
// is offered. The text channel moves one character per cycle while
// text_stall is low; a number has 1 to DIGITS + 1 characters, and the
// next number loads at the edge that takes the last character. The chain
// advances only while its last cell is empty or the serializer loads it;
// otherwise the whole chain holds and number_stall is high, which happens
// whenever a number waits in the last cell, in particular when the receiver
// stalls. Reset clears all valid flags; no characters are pending after reset.
module signed_binary_to_decimal_ascii import sbdec_pkg::*; #(
	parameter int DIGITS = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    number_valid,
	output logic                    number_stall,
	input  logic signed [MAG_W-1:0] number,
	output logic                    text_valid,
	input  logic                    text_stall,
	output logic [CHAR_W-1:0]       text_char,
	output logic                    final_char
);

	localparam int CW = $clog2(DIGITS + 1);
	localparam int BW = DIGITS * DIG_W;
	localparam logic [PROD_W-1:0] CAP = pow10(DIGITS) - PROD_W'(1);

	ctl_t             ctl_c  [DIGITS+1];
	logic [MAG_W-1:0] rem_c  [DIGITS+1];
	logic [CW-1:0]    cnt_c  [DIGITS+1];
	logic [BW-1:0]    digs_c [DIGITS+1];

	logic             adv;
	logic             load;
	logic             neg;
	logic [MAG_W-1:0] mag;
	logic [MAG_W-1:0] mag_sat;
	ctl_t             ctl_s0;
	logic [MAG_W-1:0] mag_s0;

	assign adv = !ctl_c[DIGITS].valid || load;
	assign number_stall = !adv;

	always_comb begin
		neg = number[MAG_W-1];
		mag = neg ? MAG_W'(-number) : MAG_W'(number);
		if ({{(PROD_W-MAG_W){1'b0}}, mag} > CAP) begin
			mag_sat = CAP[MAG_W-1:0];
		end else begin
			mag_sat = mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else if (adv) begin
			ctl_s0.valid <= number_valid;
			ctl_s0.neg <= neg;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s0 <= mag_sat;
		end
	end

	assign ctl_c[0] = ctl_s0;
	assign rem_c[0] = mag_s0;
	assign cnt_c[0] = '0;
	assign digs_c[0] = '0;

	for (genvar k = 0; k < DIGITS; k++) begin : g_cell
		sbdec_cell #(
			.DIGITS(DIGITS),
			.POS(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.ctl_in(ctl_c[k]),
			.rem_in(rem_c[k]),
			.cnt_in(cnt_c[k]),
			.digs_in(digs_c[k]),
			.ctl_out(ctl_c[k+1]),
			.rem_out(rem_c[k+1]),
			.cnt_out(cnt_c[k+1]),
			.digs_out(digs_c[k+1])
		);
	end

	sbdec_ser #(
		.DIGITS(DIGITS)
	) u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_in(ctl_c[DIGITS]),
		.cnt_in(cnt_c[DIGITS]),
		.digs_in(digs_c[DIGITS]),
		.load(load),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_char(text_char),
		.final_char(final_char)
	);

endmodule
